// ===== hw/rtl/pid_drive_and_turn_controller_top_defines.svh =====
// Assertion macros for the drive and turn controller.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef PID_DRIVE_AND_TURN_CONTROLLER_TOP_DEFINES_SVH
`define PID_DRIVE_AND_TURN_CONTROLLER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PDTC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PDTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pdtc_pkg.sv =====
// Shared widths, constants and unit request and response types for the drive and turn controller.
// No dependencies.
package pdtc_pkg;

	localparam int MUL_AW = 48;
	localparam int MUL_BW = 23;
	localparam int MUL_PW = 64;
	localparam int DIV_NW = 48;
	localparam int DIV_DW = 25;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 31;

	localparam int WHEEL_CIRC_DEFAULT = 411775;

	localparam logic signed [63:0] ONE_Q     = 64'sd65536;
	localparam logic signed [63:0] LIN_IMAX  = 64'sd52428800;
	localparam logic signed [63:0] LIN_FAR   = 64'sd196608;
	localparam logic signed [63:0] LIN_TOL   = 64'sd32768;
	localparam logic signed [63:0] ANG_TOL   = 64'sd65536;
	localparam logic signed [63:0] HALF_TURN = 64'sd11796480;
	localparam logic signed [63:0] INT32_HI  = 64'sd2147483647;
	localparam logic signed [63:0] INT32_LO  = -64'sd2147483648;
	localparam logic signed [63:0] MIN_MV    = 64'sd1500;
	localparam logic signed [63:0] MAX_MV    = 64'sd12000;

	localparam logic [DIV_DW-1:0] FULL_TURN_D = 25'd23592960;
	localparam logic [DIV_DW-1:0] HEAD_DIV_D  = 25'd100;
	localparam logic [DIV_DW-1:0] MS_DIV_D    = 25'd1000;
	localparam logic [DIV_DW-1:0] CIRC_DIV_D  = 25'd36000;
	localparam logic [MUL_BW-1:0] MS_MUL_B    = 23'd1000;
	localparam logic [16:0]       TOTAL_MAX   = 17'd131071;

	localparam logic [CFG_IW-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_TARGET  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_GAIN_P  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_GAIN_I  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_GAIN_D  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_I_FLOOR = 3'd5;
	localparam logic [CFG_IW-1:0] REG_I_CEIL  = 3'd6;
	localparam logic [CFG_IW-1:0] REG_TIMEOUT = 3'd7;

	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_REACHED = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [MUL_PW-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] n;
		logic [DIV_DW-1:0] d;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] q;
		logic [DIV_DW-1:0] r;
	} div_rsp_t;

endpackage

// ===== hw/rtl/pdtc_serial_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pdtc_pkg.
module pdtc_serial_mul
	import pdtc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [MUL_PW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [MUL_PW-1:0] p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= MUL_PW'(req.a);
			b_q <= req.b;
			p_q <= '0;
		end else if (busy_q && b_q != '0) begin
			// add the shifted multiplicand for each set bit, then advance
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule

// ===== hw/rtl/pdtc_serial_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on pdtc_pkg.
module pdtc_serial_div
	import pdtc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {r_q, n_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.n;
			r_q <= '0;
			d_q <= req.d;
		end else if (busy_q && cnt_q != '0) begin
			// shift in the next dividend bit; subtract when the divisor fits
			r_q <= fits ? DIV_DW'(trial - {1'b0, d_q}) : trial[DIV_DW-1:0];
			n_q <= {n_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = n_q;
	assign rsp.r    = r_q;

endmodule

// ===== hw/rtl/pid_drive_and_turn_controller_top.sv =====
// Top level of the PID drive and turn controller: sequencer, state and config.
// Depends on pdtc_pkg, pdtc_serial_mul, pdtc_serial_div and the defines header.
//
// Usage:
//   Write configuration through cfg_we/cfg_index/cfg_data while the block is
//   idle; a write takes effect at the clock edge where cfg_we is high.
//   Each control tick is one input item (start_req, elapsed_ms, sensor_value)
//   on the in_valid/in_ready channel and yields exactly one result item
//   (left_mv, right_mv, status) on the out_valid/out_ready channel.
//   A finished move answers straight from idle, without the arithmetic units. A
//   running tick shares a bit-serial multiplier and a radix-2 divider
//   (48-bit quotient loop); a full PID tick uses two to four divides.
//   The next item is taken in the cycle after the result is registered.
//   One item is worked at a time; in_ready is high whenever the sequencer
//   is idle, even while the previous result still waits in the output
//   register. If the receiver stalls, the result holds there and the next
//   item is worked up to its end, then waits for the slot to free.
//   Reset clears the move state (integral, previous error, time, first-tick
//   flag, finished code) and loads the register defaults.
`include "pid_drive_and_turn_controller_top_defines.svh"

module pid_drive_and_turn_controller_top
	import pdtc_pkg::*;
#(
	parameter int WHEEL_CIRC_Q16 = WHEEL_CIRC_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                start_req,
	input  logic [9:0]          elapsed_ms,
	input  logic signed [24:0]  sensor_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [14:0]  left_mv,
	output logic signed [14:0]  right_mv,
	output logic [1:0]          status
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LIN_MUL,
		S_LIN_DIV,
		S_ANG_DIV,
		S_WRAP_DIV,
		S_CHECK,
		S_DER_MUL,
		S_DER_DIV,
		S_INT_MUL,
		S_INT_DIV,
		S_PWR_P,
		S_PWR_I,
		S_PWR_D,
		S_FINAL,
		S_OUT
	} state_t;

	// configuration registers
	logic               mode_q;
	logic signed [27:0] target_q;
	logic [11:0]        gain_p_q;
	logic [11:0]        gain_i_q;
	logic [11:0]        gain_d_q;
	logic signed [30:0] i_floor_q;
	logic [29:0]        i_ceil_q;
	logic [15:0]        timeout_q;

	// move state
	logic signed [31:0] integ_acc_q;
	logic signed [31:0] prev_err_q;
	logic [16:0]        total_q;
	logic               first_q;
	logic [1:0]         fin_q;

	// current item and working values
	state_t             state_q;
	logic [9:0]         ms_q;
	logic               neg_q;
	logic signed [47:0] err_q;
	logic signed [47:0] deriv_q;
	logic signed [31:0] integ_q;
	logic signed [63:0] sum_q;
	logic signed [14:0] res_left_q;
	logic signed [14:0] res_right_q;
	logic [1:0]         res_status_q;

	// output register
	logic               out_valid_q;
	logic signed [14:0] out_left_q;
	logic signed [14:0] out_right_q;
	logic [1:0]         out_status_q;

	mul_req_t mul_req_q;
	mul_rsp_t mul_rsp;
	div_req_t div_req_q;
	div_rsp_t div_rsp;

	pdtc_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.rsp    (mul_rsp)
	);

	pdtc_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	logic signed [63:0] tgt_w;
	logic signed [63:0] dq_s;
	logic signed [63:0] mp_s;
	logic signed [63:0] lin_e;
	logic signed [63:0] ang_e0;
	logic signed [63:0] rem_w;
	logic signed [63:0] wrap_e;
	logic signed [63:0] err_w;
	logic signed [63:0] err_abs;
	logic signed [63:0] diff_w;
	logic signed [63:0] diff_abs;
	logic [17:0]        tot_sum;
	logic [16:0]        tot_new;
	logic signed [63:0] integ_raw;
	logic signed [63:0] integ_cl;
	logic signed [63:0] integ_abs;
	logic signed [63:0] deriv_abs;
	logic signed [63:0] sum_abs;
	logic signed [63:0] pwr;
	logic signed [63:0] pwr_min;
	logic signed [63:0] pwr_cl;
	logic               first_skip;
	logic               mul_go;
	logic               div_go;

	always_comb begin
		tgt_w     = 64'(target_q);
		dq_s      = neg_q ? -$signed({16'b0, div_rsp.q}) : $signed({16'b0, div_rsp.q});
		mp_s      = neg_q ? -$signed(mul_rsp.p) : $signed(mul_rsp.p);
		lin_e     = clamp64(tgt_w - ONE_Q - dq_s, INT32_LO, INT32_HI);
		ang_e0    = tgt_w - dq_s;
		rem_w     = $signed({39'b0, div_rsp.r});
		// wrap from the remainder: below -180 lands in [-180,180), above +180 in (-180,180]
		wrap_e    = neg_q ? (HALF_TURN - 64'sd1 - rem_w) : (rem_w + 64'sd1 - HALF_TURN);
		err_w     = 64'(err_q);
		err_abs   = abs64(err_w);
		diff_w    = err_w - 64'(prev_err_q);
		diff_abs  = abs64(diff_w);
		tot_sum   = {1'b0, total_q} + 18'(ms_q);
		tot_new   = (tot_sum > 18'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[16:0];
		first_skip = first_q || ms_q == '0;
		integ_raw = 64'(integ_acc_q) + dq_s;
		if (mode_q) begin
			// ceiling first, then floor: the floor wins when the limits cross
			integ_cl = integ_raw;
			if (integ_cl > $signed({34'b0, i_ceil_q})) integ_cl = $signed({34'b0, i_ceil_q});
			if (integ_cl < 64'(i_floor_q)) integ_cl = 64'(i_floor_q);
		end else begin
			integ_cl = clamp64(integ_raw, -LIN_IMAX, LIN_IMAX);
		end
		integ_abs = abs64(64'(integ_q));
		deriv_abs = abs64(64'(deriv_q));
		// scale by 1/65536 with truncation toward zero
		sum_abs   = abs64(sum_q);
		pwr       = sum_q < 0 ? -(sum_abs >>> 16) : (sum_abs >>> 16);
		pwr_min   = pwr;
		if (mode_q || err_abs > LIN_FAR) begin
			if (pwr > 0 && pwr < MIN_MV) pwr_min = MIN_MV;
			if (pwr < 0 && pwr > -MIN_MV) pwr_min = -MIN_MV;
		end
		pwr_cl    = clamp64(pwr_min, -MAX_MV, MAX_MV);
	end

	// launch pulses for the shared multiplier and divider
	always_comb begin
		mul_go = 1'b0;
		div_go = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && (start_req || fin_q == ST_RUN)) begin
					if (mode_q) begin
						div_go = 1'b1;
					end else begin
						mul_go = 1'b1;
					end
				end
			end
			S_LIN_MUL, S_DER_MUL, S_INT_MUL: div_go = mul_rsp.done;
			S_ANG_DIV: div_go = div_rsp.done && (ang_e0 > HALF_TURN || ang_e0 < -HALF_TURN);
			S_CHECK: mul_go = !(tot_new >= 17'(timeout_q)) &&
				!(err_abs < (mode_q ? ANG_TOL : LIN_TOL));
			S_DER_DIV, S_INT_DIV: mul_go = div_rsp.done;
			S_PWR_P, S_PWR_I: mul_go = mul_rsp.done;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// configuration writes; the list covers every index, so the default arm is never taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			target_q  <= '0;
			gain_p_q  <= 12'd320;
			gain_i_q  <= 12'd150;
			gain_d_q  <= 12'd55;
			i_floor_q <= -31'sd786432000;
			i_ceil_q  <= 30'd786432000;
			timeout_q <= 16'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= cfg_data[0];
				REG_TARGET:  target_q  <= $signed(cfg_data[27:0]);
				REG_GAIN_P:  gain_p_q  <= cfg_data[11:0];
				REG_GAIN_I:  gain_i_q  <= cfg_data[11:0];
				REG_GAIN_D:  gain_d_q  <= cfg_data[11:0];
				REG_I_FLOOR: i_floor_q <= $signed(cfg_data[30:0]);
				REG_I_CEIL:  i_ceil_q  <= cfg_data[29:0];
				REG_TIMEOUT: timeout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer: one item at a time through the shared multiplier and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			integ_acc_q     <= '0;
			prev_err_q      <= '0;
			total_q         <= '0;
			first_q         <= 1'b1;
			fin_q           <= ST_RUN;
			out_valid_q     <= 1'b0;
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			mul_req_q.start <= mul_go;
			div_req_q.start <= div_go;
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ms_q     <= elapsed_ms;
						if (start_req) begin
							integ_acc_q <= '0;
							prev_err_q  <= '0;
							total_q     <= '0;
							first_q     <= 1'b1;
							fin_q       <= ST_RUN;
						end
						if (!start_req && fin_q != ST_RUN) begin
							// move already over: answer with zero drive, keep state
							res_left_q   <= '0;
							res_right_q  <= '0;
							res_status_q <= fin_q;
							state_q      <= S_OUT;
						end else if (mode_q) begin
							neg_q           <= sensor_value[24];
							div_req_q.n     <= DIV_NW'(abs64(64'(sensor_value)) << 16);
							div_req_q.d     <= HEAD_DIV_D;
							state_q         <= S_ANG_DIV;
						end else begin
							neg_q           <= sensor_value[24];
							mul_req_q.a     <= MUL_AW'(abs64(64'(sensor_value)));
							mul_req_q.b     <= MUL_BW'(WHEEL_CIRC_Q16);
							state_q         <= S_LIN_MUL;
						end
					end
				end
				S_LIN_MUL: begin
					if (mul_rsp.done) begin
						div_req_q.n     <= mul_rsp.p[DIV_NW-1:0];
						div_req_q.d     <= CIRC_DIV_D;
						state_q         <= S_LIN_DIV;
					end
				end
				S_LIN_DIV: begin
					if (div_rsp.done) begin
						err_q   <= lin_e[47:0];
						state_q <= S_CHECK;
					end
				end
				S_ANG_DIV: begin
					if (div_rsp.done) begin
						if (ang_e0 > HALF_TURN) begin
							neg_q           <= 1'b0;
							div_req_q.n     <= DIV_NW'(ang_e0 - HALF_TURN - 64'sd1);
							div_req_q.d     <= FULL_TURN_D;
							state_q         <= S_WRAP_DIV;
						end else if (ang_e0 < -HALF_TURN) begin
							neg_q           <= 1'b1;
							div_req_q.n     <= DIV_NW'(-HALF_TURN - ang_e0 - 64'sd1);
							div_req_q.d     <= FULL_TURN_D;
							state_q         <= S_WRAP_DIV;
						end else begin
							err_q   <= ang_e0[47:0];
							state_q <= S_CHECK;
						end
					end
				end
				S_WRAP_DIV: begin
					if (div_rsp.done) begin
						err_q   <= wrap_e[47:0];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					total_q <= tot_new;
					if (tot_new >= 17'(timeout_q)) begin
						fin_q        <= ST_TIMEOUT;
						res_left_q   <= '0;
						res_right_q  <= '0;
						res_status_q <= ST_TIMEOUT;
						state_q      <= S_OUT;
					end else if (err_abs < (mode_q ? ANG_TOL : LIN_TOL)) begin
						fin_q        <= ST_REACHED;
						res_left_q   <= '0;
						res_right_q  <= '0;
						res_status_q <= ST_REACHED;
						state_q      <= S_OUT;
					end else if (first_skip) begin
						// no derivative on the first tick or a zero interval
						first_q         <= 1'b0;
						deriv_q         <= '0;
						neg_q           <= err_w < 0;
						mul_req_q.a     <= MUL_AW'(err_abs);
						mul_req_q.b     <= MUL_BW'(ms_q);
						state_q         <= S_INT_MUL;
					end else begin
						neg_q           <= diff_w < 0;
						mul_req_q.a     <= MUL_AW'(diff_abs);
						mul_req_q.b     <= MS_MUL_B;
						state_q         <= S_DER_MUL;
					end
				end
				S_DER_MUL: begin
					if (mul_rsp.done) begin
						div_req_q.n     <= mul_rsp.p[DIV_NW-1:0];
						div_req_q.d     <= DIV_DW'(ms_q);
						state_q         <= S_DER_DIV;
					end
				end
				S_DER_DIV: begin
					if (div_rsp.done) begin
						deriv_q         <= dq_s[47:0];
						neg_q           <= err_w < 0;
						mul_req_q.a     <= MUL_AW'(err_abs);
						mul_req_q.b     <= MUL_BW'(ms_q);
						state_q         <= S_INT_MUL;
					end
				end
				S_INT_MUL: begin
					if (mul_rsp.done) begin
						div_req_q.n     <= mul_rsp.p[DIV_NW-1:0];
						div_req_q.d     <= MS_DIV_D;
						state_q         <= S_INT_DIV;
					end
				end
				S_INT_DIV: begin
					if (div_rsp.done) begin
						integ_q         <= integ_cl[31:0];
						sum_q           <= '0;
						neg_q           <= err_w < 0;
						mul_req_q.a     <= MUL_AW'(err_abs);
						mul_req_q.b     <= MUL_BW'(gain_p_q);
						state_q         <= S_PWR_P;
					end
				end
				S_PWR_P: begin
					if (mul_rsp.done) begin
						sum_q           <= sum_q + mp_s;
						neg_q           <= integ_q < 0;
						mul_req_q.a     <= MUL_AW'(integ_abs);
						mul_req_q.b     <= MUL_BW'(gain_i_q);
						state_q         <= S_PWR_I;
					end
				end
				S_PWR_I: begin
					if (mul_rsp.done) begin
						sum_q           <= sum_q + mp_s;
						neg_q           <= deriv_q < 0;
						mul_req_q.a     <= MUL_AW'(deriv_abs);
						mul_req_q.b     <= MUL_BW'(gain_d_q);
						state_q         <= S_PWR_D;
					end
				end
				S_PWR_D: begin
					if (mul_rsp.done) begin
						sum_q   <= sum_q + mp_s;
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					integ_acc_q  <= integ_q;
					prev_err_q   <= err_q[31:0];
					res_left_q   <= pwr_cl[14:0];
					res_right_q  <= mode_q ? 15'(-pwr_cl) : pwr_cl[14:0];
					res_status_q <= ST_RUN;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free, then hand the item over
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_left_q   <= res_left_q;
						out_right_q  <= res_right_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign left_mv   = out_left_q;
	assign right_mv  = out_right_q;
	assign status    = out_status_q;

	`PDTC_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready, state_q != S_IDLE, "accepted item left sequencer idle")
	`PDTC_ASSERT(a_done_has_no_drive, !(out_valid && status != ST_RUN) || (left_mv == 15'sd0 && right_mv == 15'sd0), "finished result carries drive")
	`PDTC_ASSERT(a_drive_in_range, !out_valid || (left_mv <= 15'sd12000 && left_mv >= -15'sd12000), "drive out of range")
	`PDTC_ASSERT(a_turn_mirrors, !(out_valid && mode_q && status == ST_RUN) || (right_mv == -left_mv), "turn drive not mirrored")

endmodule
